@@ sv/lzwc_pkg.sv @@
// ---------------------------------------------------------------------------
// lzwc_pkg
// Shared types and constants of the LZW byte compressor.
// ---------------------------------------------------------------------------
package lzwc_pkg;

	localparam int MaxCodeBitsDef = 12;
	localparam int FirstFree      = 256;
	localparam int StartWidth     = 9;
	localparam int CodeMaxW       = 16;
	localparam int WidthW         = 5;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       stream_end;
	} out_item_t;

	// code handed to the bit packer
	typedef struct packed {
		logic                valid;
		logic [CodeMaxW-1:0] code;
		logic [WidthW-1:0]   width;
		logic                last;
	} pk_cmd_t;

	// lookup answer from the dictionary
	typedef struct packed {
		logic                done;
		logic                hit;
		logic [CodeMaxW-1:0] code;
	} dict_rsp_t;

endpackage

@@ sv/lzw_byte_compressor_core.sv @@
// ---------------------------------------------------------------------------
// lzw_byte_compressor_core
// LZW compressor, variable code width from 9 up to MAX_CODE_BITS, packed
// MSB-first into bytes.
// ---------------------------------------------------------------------------
//  channel | handshake               | item
//  --------+-------------------------+----------------------------------
//  input   | byte_valid / byte_stall | byte_item {in_byte, last_byte}
//  output  | code_valid / code_stall | code_item {out_byte, stream_end}
//
//  Steps: the first byte of a stream only becomes the prefix; any other byte
//  is looked up by probes, each a slot-table read then a code-table read.
//  A miss then emits the prefix and adds the string, and the last byte flushes
//  the pending code; output bytes drain one per cycle while code_stall is low.
//  Reset: the slot table is swept with byte_stall high.
//  Stalls on the output hold the packer; input stalls while a code waits.
// ---------------------------------------------------------------------------
module lzw_byte_compressor_core import lzwc_pkg::*; #(
	parameter int MAX_CODE_BITS = MaxCodeBitsDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_item,
	output logic      code_valid,
	input  logic      code_stall,
	output out_item_t code_item
);

	localparam int CB    = MAX_CODE_BITS;
	localparam int DSIZE = 1 << CB;

	typedef enum logic [1:0] {T_IDLE, T_LOOK, T_MISS, T_LAST} state_t;

	state_t            state_q;
	logic [CB-1:0]     prefix_q;
	logic              pv_q;
	logic [CB:0]       nf_q, nf_new;
	logic [WidthW-1:0] width_q;
	logic [7:0]        byte_q;
	logic              last_q;

	logic              accept, dict_rdy, pk_rdy, full, grow;
	logic              req_valid, ins_valid;
	dict_rsp_t         rsp;
	pk_cmd_t           pk_cmd;

	lzwc_dict #(.MAX_CODE_BITS(CB)) u_dict (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_key  ({prefix_q, byte_item.in_byte}),
		.nxt_free (nf_q),
		.ins_valid(ins_valid),
		.ins_code (nf_q[CB-1:0]),
		.rdy      (dict_rdy),
		.rsp      (rsp)
	);

	lzwc_pack #(.MAX_CODE_BITS(CB)) u_pack (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (pk_cmd),
		.rdy   (pk_rdy),
		.valid (code_valid),
		.stall (code_stall),
		.item  (code_item)
	);

	// take a byte only when idle and the table sweep is done
	assign byte_stall = !(state_q == T_IDLE && dict_rdy);
	assign accept     = byte_valid && !byte_stall;
	assign req_valid  = accept && pv_q;

	// dictionary full: stop adding entries, width stays put
	assign full   = (nf_q == (CB+1)'(DSIZE));
	assign nf_new = full ? nf_q : nf_q + (CB+1)'(1);
	assign grow   = (width_q < WidthW'(CB)) && (32'(nf_new) == (32'd1 << width_q));
	assign ins_valid = (state_q == T_MISS) && pk_rdy && !full;

	always_comb begin
		pk_cmd.valid = 1'b0;
		pk_cmd.code  = CodeMaxW'(prefix_q);
		pk_cmd.width = width_q;
		pk_cmd.last  = (state_q == T_LAST);
		if ((state_q == T_MISS || state_q == T_LAST) && pk_rdy) pk_cmd.valid = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_IDLE;
			prefix_q <= '0;
			pv_q     <= 1'b0;
			nf_q     <= (CB+1)'(FirstFree);
			width_q  <= WidthW'(StartWidth);
			byte_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						byte_q <= byte_item.in_byte;
						last_q <= byte_item.last_byte;
						if (!pv_q) begin
							prefix_q <= CB'(byte_item.in_byte);
							pv_q     <= 1'b1;
							state_q  <= byte_item.last_byte ? T_LAST : T_IDLE;
						end else begin
							state_q <= T_LOOK;
						end
					end
				end
				T_LOOK: begin
					if (rsp.done) begin
						if (rsp.hit) begin
							prefix_q <= rsp.code[CB-1:0];
							state_q  <= last_q ? T_LAST : T_IDLE;
						end else begin
							state_q <= T_MISS;
						end
					end
				end
				T_MISS: begin
					// emit the prefix, add the new string unless the dictionary is full, restart from this byte
					if (pk_rdy) begin
						nf_q     <= nf_new;
						if (grow) width_q <= width_q + WidthW'(1);
						prefix_q <= CB'(byte_q);
						state_q  <= last_q ? T_LAST : T_IDLE;
					end
				end
				T_LAST: begin
					// flush the pending code and start a fresh stream
					if (pk_rdy) begin
						prefix_q <= '0;
						pv_q     <= 1'b0;
						nf_q     <= (CB+1)'(FirstFree);
						width_q  <= WidthW'(StartWidth);
						state_q  <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	a_nf_range: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q >= (CB+1)'(FirstFree) && nf_q <= (CB+1)'(DSIZE))
		else $error("next free code out of range");

	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		width_q >= WidthW'(StartWidth) && width_q <= WidthW'(CB))
		else $error("code width out of range");

	a_pack_free: assert property (@(posedge clk) disable iff (!arst_n)
		pk_cmd.valid |-> pk_rdy)
		else $error("code handed to busy packer");

	a_look_idle_in: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == T_LOOK |-> byte_stall)
		else $error("input taken during lookup");

endmodule

@@ sv/lzwc_dict.sv @@
// ---------------------------------------------------------------------------
// lzwc_dict
// Hashed dictionary: a slot table of codes and a code table of {key, slot},
// linear probing, each probe a slot-table read then a code-table read.
// ---------------------------------------------------------------------------
module lzwc_dict import lzwc_pkg::*; #(
	parameter int MAX_CODE_BITS = MaxCodeBitsDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	input  logic [MAX_CODE_BITS+7:0] req_key,
	input  logic [MAX_CODE_BITS:0]   nxt_free,
	input  logic                     ins_valid,
	input  logic [MAX_CODE_BITS-1:0] ins_code,
	output logic                     rdy,
	output dict_rsp_t                rsp
);

	localparam int CB    = MAX_CODE_BITS;
	localparam int HB    = CB + 1;
	localparam int KW    = CB + 8;
	localparam int HSIZE = 1 << HB;
	localparam int DSIZE = 1 << CB;

	typedef enum logic [1:0] {D_CLEAR, D_IDLE, D_HREAD, D_CREAD} state_t;

	logic [CB-1:0]      hmem [HSIZE];
	logic [KW+HB-1:0]   cmem [DSIZE];

	state_t             state_q;
	logic [HB-1:0]      clr_q;
	logic [HB-1:0]      slot_q;
	logic [KW-1:0]      key_q;
	logic [CB-1:0]      hcode_s1;
	logic [KW+HB-1:0]   cdata_s1;

	logic               h_re, h_we, c_re;
	logic [HB-1:0]      h_raddr, h_waddr;
	logic [CB-1:0]      h_wdata;
	logic               live, hit;

	function automatic logic [HB-1:0] hash_key(input logic [KW-1:0] k);
		hash_key = {1'b0, k[KW-1:8]} ^ {k[7:0], {(HB-8){1'b0}}};
	endfunction

	assign live = ({1'b0, hcode_s1} >= HB'(FirstFree)) && ({1'b0, hcode_s1} < nxt_free)
		&& (cdata_s1[HB-1:0] == slot_q);
	assign hit  = live && (cdata_s1[KW+HB-1:HB] == key_q);

	always_comb begin
		h_re    = 1'b0;
		h_raddr = slot_q + HB'(1);
		h_we    = 1'b0;
		h_waddr = slot_q;
		h_wdata = ins_code;
		c_re    = 1'b0;
		unique case (state_q)
			D_CLEAR: begin
				h_we    = 1'b1;
				h_waddr = clr_q;
				h_wdata = '0;
			end
			D_IDLE: begin
				if (ins_valid) begin
					h_we = 1'b1;
				end else if (req_valid) begin
					h_re    = 1'b1;
					h_raddr = hash_key(req_key);
				end
			end
			D_HREAD: c_re = 1'b1;
			D_CREAD: h_re = live && !hit;
			default: ;
		endcase
	end

	assign rdy      = (state_q == D_IDLE);
	assign rsp.done = (state_q == D_CREAD) && (hit || !live);
	assign rsp.hit  = hit;
	assign rsp.code = CodeMaxW'(hcode_s1);

	always_ff @(posedge clk) begin
		if (h_we) hmem[h_waddr] <= h_wdata;
		if (h_re) hcode_s1 <= hmem[h_raddr];
		if (state_q == D_IDLE && ins_valid) cmem[ins_code] <= {key_q, slot_q};
		if (c_re) cdata_s1 <= cmem[hcode_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_CLEAR;
			clr_q   <= '0;
			slot_q  <= '0;
			key_q   <= '0;
		end else begin
			unique case (state_q)
				D_CLEAR: begin
					clr_q <= clr_q + HB'(1);
					if (clr_q == HB'(HSIZE - 1)) state_q <= D_IDLE;
				end
				D_IDLE: begin
					if (!ins_valid && req_valid) begin
						key_q   <= req_key;
						slot_q  <= hash_key(req_key);
						state_q <= D_HREAD;
					end
				end
				D_HREAD: state_q <= D_CREAD;
				D_CREAD: begin
					if (hit || !live) begin
						state_q <= D_IDLE;
					end else begin
						slot_q  <= slot_q + HB'(1);
						state_q <= D_HREAD;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

endmodule

@@ sv/lzwc_pack.sv @@
// ---------------------------------------------------------------------------
// lzwc_pack
// Bit packer: takes variable-width codes, drains MSB-first bytes one per cycle while not stalled.
// ---------------------------------------------------------------------------
module lzwc_pack import lzwc_pkg::*; #(
	parameter int MAX_CODE_BITS = MaxCodeBitsDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  pk_cmd_t   cmd,
	output logic      rdy,
	output logic      valid,
	input  logic      stall,
	output out_item_t item
);

	localparam int AW = MAX_CODE_BITS + 7;
	localparam int CW = $clog2(AW + 1);

	logic [AW-1:0] acc_q;
	logic [CW-1:0] cnt_q, cnt_n;
	logic          last_q, ov_q, busy, take;
	logic [7:0]    byte_n;
	out_item_t     item_q;

	assign busy = (cnt_q >= CW'(8)) || (last_q && cnt_q != '0);
	assign take = busy && (!ov_q || !stall);
	assign rdy  = !busy;

	always_comb begin
		if (cnt_q >= CW'(8)) begin
			byte_n = 8'(acc_q >> (cnt_q - CW'(8)));
			cnt_n  = cnt_q - CW'(8);
		end else begin
			// pad the tail with zeros
			byte_n = 8'(acc_q << (CW'(8) - cnt_q));
			cnt_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			cnt_q  <= '0;
			last_q <= 1'b0;
			ov_q   <= 1'b0;
			item_q <= '0;
		end else begin
			if (take) begin
				ov_q   <= 1'b1;
				item_q <= '{out_byte: byte_n, stream_end: last_q && cnt_n == '0};
				cnt_q  <= cnt_n;
				if (cnt_n == '0) last_q <= 1'b0;
			end else if (ov_q && !stall) begin
				ov_q <= 1'b0;
			end
			if (cmd.valid) begin
				acc_q  <= (acc_q << cmd.width) | AW'(cmd.code);
				cnt_q  <= cnt_q + CW'(cmd.width);
				last_q <= cmd.last;
			end
		end
	end

	assign valid = ov_q;
	assign item  = item_q;

endmodule

@@ tb/lzw_byte_compressor_checker.sv @@
// ---------------------------------------------------------------------------
// lzw_byte_compressor_checker
// Watches both channels of the compressor, predicts the packed code bytes
// of every accepted input item and compares them with the output items.
// ---------------------------------------------------------------------------
module lzw_byte_compressor_checker import lzwc_pkg::*; #(
	parameter int MAX_CODE_BITS = MaxCodeBitsDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	input  logic      byte_stall,
	input  in_item_t  byte_item,
	input  logic      code_valid,
	input  logic      code_stall,
	input  out_item_t code_item,
	output int        errors,
	output int        pending,
	output int        bytes_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TableSize = 1 << MAX_CODE_BITS;

	int unsigned code_of_string[logic [31:0]];
	int unsigned prefix;
	bit          prefix_held;
	int unsigned free_code;
	int unsigned code_bits;
	logic [7:0]  acc_bits;
	int unsigned open_bits;
	out_item_t   bytes_due[$];
	int          mismatches;
	int          checked;

	assign errors        = mismatches;
	assign bytes_checked = checked;

	function automatic void restart_stream();
		code_of_string.delete();
		prefix      = 0;
		prefix_held = 0;
		free_code   = FirstFree;
		code_bits   = StartWidth;
		acc_bits    = '0;
		open_bits   = 8;
	endfunction

	// append one expected byte at the tail of the queue
	function automatic void add_due(out_item_t o);
		bytes_due.insert(bytes_due.size(), o);
	endfunction

	// shift a code in MSB first, queue every completed byte
	function automatic void pack_code(logic [31:0] code, int unsigned nbits);
		out_item_t o;
		for (int i = nbits; i > 0; i--) begin
			acc_bits[open_bits-1] = code[i-1];
			open_bits--;
			if (open_bits == 0) begin
				o.out_byte   = acc_bits;
				o.stream_end = 1'b0;
				add_due(o);
				acc_bits  = '0;
				open_bits = 8;
			end
		end
	endfunction

	function automatic void compress_byte(in_item_t it);
		logic [31:0] key;
		out_item_t   o;
		if (!prefix_held) begin
			prefix      = it.in_byte;
			prefix_held = 1;
		end else begin
			key = (prefix << 8) | it.in_byte;
			if (code_of_string.exists(key)) begin
				prefix = code_of_string[key];
			end else begin
				if (free_code < TableSize) begin
					code_of_string[key] = free_code;
					free_code++;
				end
				pack_code(prefix, code_bits);
				if (code_bits < MAX_CODE_BITS && free_code == (1 << code_bits))
					code_bits++;
				prefix = it.in_byte;
			end
		end
		if (it.last_byte) begin
			pack_code(prefix, code_bits);
			if (open_bits < 8) begin
				o.out_byte   = acc_bits;
				o.stream_end = 1'b0;
				add_due(o);
			end
			bytes_due[bytes_due.size()-1].stream_end = 1'b1;
			restart_stream();
		end
	endfunction

	initial begin
		mismatches = 0;
		checked    = 0;
		restart_stream();
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			// outputs first, so an item never meets its own expectation
			if (code_valid && !code_stall) begin
				checked++;
				if (bytes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected output item %h/%b", $realtime,
							code_item.out_byte, code_item.stream_end);
				end else begin
					want = bytes_due.pop_front();
					if (want != code_item) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: out_byte exp %h got %h, stream_end exp %b got %b",
								$realtime, want.out_byte, code_item.out_byte,
								want.stream_end, code_item.stream_end);
					end
				end
			end
			if (byte_valid && !byte_stall)
				compress_byte(byte_item);
		end
		pending = bytes_due.size();
	end

endmodule

@@ tb/lzw_byte_compressor_core_test.sv @@
// ---------------------------------------------------------------------------
// lzw_byte_compressor_core_test
// Drives byte streams into the LZW compressor under varying idle and stall
// patterns; a checker beside the block predicts and compares the code bytes.
// ---------------------------------------------------------------------------
module lzw_byte_compressor_core_test;
	import lzwc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 30000;  // covers the table sweep after reset
	localparam int LongHold      = 400;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_item = '0;
	logic      code_valid;
	logic      code_stall = 1'b0;
	out_item_t code_item;

	int errors, pending, bytes_checked;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_ticket = 0;
	int items_sent = 0;
	int streams_sent = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	lzw_byte_compressor_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item (byte_item),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_item (code_item)
	);

	lzw_byte_compressor_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.code_valid   (code_valid),
		.code_stall   (code_stall),
		.code_item    (code_item),
		.errors       (errors),
		.pending      (pending),
		.bytes_checked(bytes_checked)
	);

	// Receiver: stall at random, or hold off for a long stretch on request.
	always @(posedge clk) begin
		static int seen_ticket = 0;
		static int hold_left = 0;
		if (hold_ticket != seen_ticket) begin
			seen_ticket = hold_ticket;
			hold_left = LongHold;
		end
		if (hold_left > 0) begin
			hold_left--;
			code_stall <= 1'b1;
		end else begin
			code_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (code_valid && !code_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("watchdog: no item moved for %0d cycles", WatchdogLimit);
			$display("lzw_byte_compressor_core_test: done, errors");
			$finish;
		end
	end

	// Offer one item; hold it until accepted. Settled values are read at the
	// falling edge, since every input changes only at the rising edge.
	// Valid stays high after the accepting edge; the next idle cycle or the
	// next item replaces it.
	task automatic send_byte(logic [7:0] b, logic last);
		bit taken;
		while ($urandom_range(99) < tx_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_item  <= '{in_byte: b, last_byte: last};
		byte_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !byte_stall;
			@(posedge clk);
		end while (!taken);
		items_sent++;
		if (last)
			streams_sent++;
	endtask

	// Drop valid, wait for every expected byte, then let the block settle.
	task automatic drain();
		byte_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	// One stream: mostly a narrow alphabet so strings repeat and hit.
	task automatic send_stream(int len, int alphabet);
		for (int i = 0; i < len; i++)
			send_byte(alphabet >= 256 ? 8'($urandom_range(255))
				: 8'($urandom_range(alphabet - 1) + 8'h61), i == len - 1);
	endtask

	initial begin
		int phase_tx[4] = '{0, 73, 0, 15};
		int phase_rx[4] = '{0, 0, 73, 15};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// single-byte streams at both ends of the byte range
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// one run of a repeated byte, then a short mixed stream
		for (int i = 0; i < 8; i++)
			send_byte(8'h41, i == 7);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b1);
		drain();

		// receiver holds off while the sender keeps offering items
		hold_ticket++;
		send_stream(12, 3);
		drain();

		// one random stream across all idle phases: enough misses to widen
		// the codes past 9 bits
		for (int p = 0; p < 4; p++) begin
			tx_idle_pct  = phase_tx[p];
			rx_stall_pct = phase_rx[p];
			for (int i = 0; i < 66; i++)
				send_byte(8'($urandom_range(255)), p == 3 && i == 65);
		end
		// a new stream right after must start from a clean table
		send_stream(8, 3);
		drain();

		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		drain();
		repeat (50) @(posedge clk);
		$display("covered %0d input items in %0d streams, %0d code bytes checked",
			items_sent, streams_sent, bytes_checked);
		$display("incl. width growth, single-byte streams, long output hold, idle phases");
		if (errors == 0 && pending == 0)
			$display("lzw_byte_compressor_core_test: done, clean");
		else
			$display("lzw_byte_compressor_core_test: done, errors");
		$finish;
	end

endmodule
